@@ design/flc_pkg.sv @@
// Shared types and constants for the full-length FIR line correlator.
// Used by flc_front, flc_back and fir_line_full_correlation; flc_fifo stands alone.
package flc_pkg;

  // Default filter geometry.
  localparam int MaxTapsDef  = 28;
  localparam int CoefBitsDef = 16;

  // Tap register file: seven 64-bit registers, four 16-bit lanes each.
  localparam int TapRegs   = 7;
  localparam int RegW      = 64;
  localparam int LaneW     = 16;
  localparam int TapLanes  = TapRegs * RegW / LaneW;

  // Sample and result widths, tap count register width and its reset value.
  localparam int SampleW     = 16;
  localparam int CntW        = 5;
  localparam int TapCountRst = 4;

  // Queue depths on each side of the engine.
  localparam int QueueDepth = 2;
  localparam int OutDepth   = 2;

  // Configuration register indexes.
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_TAPS_0_3   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TAPS_24_27 = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_TAP_COUNT  = 3'd7;

  // Item handed from the front to the back.
  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               row_end;
    logic               row_first;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [SampleW-1:0] value;
    logic               last;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LEAD,
    BK_MAC,
    BK_DRAIN,
    BK_EMIT
  } back_state_e;

endpackage

@@ design/flc_fifo.sv @@
// Small synchronous FIFO with registered storage and occupancy count.
// Standalone; no package dependency.
module flc_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OccW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [OccW-1:0]  count_q;
  logic             do_wr, do_rd;

  assign full_o  = (count_q == OccW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ design/flc_front.sv @@
// Front end: accepts samples, tags the first sample of each row, queues items.
// Depends on flc_pkg and flc_fifo.
module flc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic [flc_pkg::SampleW-1:0]    sample_i,
  input  logic                           row_end_i,
  output flc_pkg::item_t                 item_o,
  output logic                           item_valid_o,
  input  logic                           pop_i
);

  logic           first_q;
  logic           accept;
  logic           empty;
  flc_pkg::item_t item_in;

  assign accept = push_i && !full_o;

  always_comb begin
    item_in.sample    = sample_i;
    item_in.row_end   = row_end_i;
    item_in.row_first = first_q;
  end

  // The sample after a row end opens a new row.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else if (accept) begin
      first_q <= row_end_i;
    end
  end

  flc_fifo #(
    .WIDTH ($bits(flc_pkg::item_t)),
    .DEPTH (flc_pkg::QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (accept),
    .wdata_i (item_in),
    .full_o  (full_o),
    .rd_i    (pop_i),
    .rdata_o (item_o),
    .empty_o (empty)
  );

  assign item_valid_o = !empty;

endmodule

@@ design/flc_back.sv @@
// Back end: history line, shared multiply-accumulate, rounding and row flush.
// Depends on flc_pkg.
module flc_back #(
  parameter int MAX_TAPS  = flc_pkg::MaxTapsDef,
  parameter int COEF_BITS = flc_pkg::CoefBitsDef
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic [flc_pkg::TapLanes-1:0][flc_pkg::LaneW-1:0] taps_i,
  input  logic [flc_pkg::CntW-1:0]                       tap_count_i,
  input  flc_pkg::item_t                                 item_i,
  input  logic                                           item_valid_i,
  output logic                                           q_pop_o,
  output flc_pkg::result_t                               res_o,
  output logic                                           res_push_o,
  input  logic                                           res_full_i
);

  localparam int TapW   = (COEF_BITS < flc_pkg::LaneW) ? COEF_BITS : flc_pkg::LaneW;
  localparam int HistN  = MAX_TAPS - 1;
  localparam int ProdW  = flc_pkg::SampleW + 1 + TapW;
  localparam int AccW   = flc_pkg::SampleW + TapW + $clog2(MAX_TAPS) + 1;
  localparam int CntW   = flc_pkg::CntW;
  localparam int SW     = flc_pkg::SampleW;
  localparam logic signed [AccW-1:0] RndHalf = AccW'(1) << (COEF_BITS - 2);

  flc_pkg::back_state_e state_q, state_d;

  logic [SW-1:0]   hist_q [HistN];
  logic [SW-1:0]   newest_q;
  logic            end_q;
  logic [CntW-1:0] flush_left_q;
  logic [CntW-1:0] j_q;
  logic            pv_q;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic signed [AccW-1:0]  acc_q;

  logic [CntW-1:0] t_act, t_last, age, age_m1;
  logic [SW-1:0]   x_sel;
  logic signed [TapW-1:0] tap_sel;
  logic signed [AccW-1:0] rnd, shf;
  logic [SW-1:0]   rounded;
  logic            load, start, hist_push, hist_clr, refill;

  // Clamp the tap count to 1..MAX_TAPS.
  always_comb begin
    t_act = tap_count_i;
    if (t_act == '0) begin
      t_act = CntW'(1);
    end else if (int'(t_act) > MAX_TAPS) begin
      t_act = CntW'(MAX_TAPS);
    end
    t_last = t_act - 1'b1;
  end

  // Operand select for tap j: newest sample pairs with the last tap.
  always_comb begin
    age    = t_last - j_q;
    age_m1 = age - 1'b1;
    x_sel  = newest_q;
    if (age != '0) begin
      x_sel = '0;
      for (int i = 0; i < HistN; i++) begin
        if (int'(age_m1) == i) begin
          x_sel = hist_q[i];
        end
      end
    end
    tap_sel = '0;
    if (j_q < CntW'(flc_pkg::TapLanes)) begin
      tap_sel = taps_i[j_q][TapW-1:0];
    end
    prod_d = $signed({1'b0, x_sel}) * tap_sel;
  end

  // Round half up, then saturate to the unsigned output range.
  always_comb begin
    rnd = acc_q + RndHalf;
    shf = rnd >>> (COEF_BITS - 1);
    if (rnd[AccW-1]) begin
      rounded = '0;
    end else if (|shf[AccW-1:SW]) begin
      rounded = '1;
    end else begin
      rounded = shf[SW-1:0];
    end
  end

  always_comb begin
    state_d    = state_q;
    q_pop_o    = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    load       = 1'b0;
    start      = 1'b0;
    hist_push  = 1'b0;
    hist_clr   = 1'b0;
    refill     = 1'b0;
    case (state_q)
      flc_pkg::BK_IDLE: begin
        if (item_valid_i) begin
          q_pop_o = 1'b1;
          load    = 1'b1;
          if (item_i.row_first) begin
            state_d = flc_pkg::BK_LEAD;
          end else begin
            state_d = flc_pkg::BK_MAC;
            start   = 1'b1;
          end
        end
      end
      flc_pkg::BK_LEAD: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = flc_pkg::BK_MAC;
          start      = 1'b1;
        end
      end
      flc_pkg::BK_MAC: begin
        if (j_q == t_last) begin
          state_d = flc_pkg::BK_DRAIN;
        end
      end
      flc_pkg::BK_DRAIN: begin
        state_d = flc_pkg::BK_EMIT;
      end
      flc_pkg::BK_EMIT: begin
        if (!res_full_i) begin
          res_push_o    = 1'b1;
          res_o.value   = rounded;
          res_o.last    = end_q && (flush_left_q == '0);
          hist_push     = 1'b1;
          if (end_q && (flush_left_q != '0)) begin
            refill  = 1'b1;
            start   = 1'b1;
            state_d = flc_pkg::BK_MAC;
          end else begin
            hist_clr = end_q;
            state_d  = flc_pkg::BK_IDLE;
          end
        end
      end
      default: state_d = flc_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= flc_pkg::BK_IDLE;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pv_q    <= (state_q == flc_pkg::BK_MAC);
    end
  end

  // History line: shift in the sample just used, clear at row end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HistN; i++) begin
        hist_q[i] <= '0;
      end
    end else if (hist_clr) begin
      for (int i = 0; i < HistN; i++) begin
        hist_q[i] <= '0;
      end
    end else if (hist_push) begin
      hist_q[0] <= newest_q;
      for (int i = 1; i < HistN; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      newest_q     <= item_i.sample;
      end_q        <= item_i.row_end;
      flush_left_q <= item_i.row_end ? t_last : '0;
    end else if (refill) begin
      newest_q     <= '0;
      flush_left_q <= flush_left_q - 1'b1;
    end
    if (start) begin
      j_q <= '0;
    end else if (state_q == flc_pkg::BK_MAC) begin
      j_q <= j_q + 1'b1;
    end
    prod_q <= prod_d;
    if (start) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
  end

`ifndef ASSERT_OFF
  a_mac_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == flc_pkg::BK_MAC |-> j_q <= t_last)
    else $error("tap index ran past the tap count");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result written into a full output queue");

  a_drain_product: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == flc_pkg::BK_DRAIN |-> pv_q)
    else $error("drain cycle without a pending product");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.last) |=> (state_q == flc_pkg::BK_IDLE && hist_q[0] == '0))
    else $error("row end did not return to idle with a cleared history");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == flc_pkg::BK_IDLE && item_valid_i))
    else $error("queue popped outside idle");
`endif

endmodule

@@ design/fir_line_full_correlation.sv @@
// Full-length FIR correlation of sample rows: top level with tap registers.
// Depends on flc_pkg, flc_fifo, flc_front and flc_back.
//
// Usage:
//   Input channel is a queue: drive sample_i/row_end_i and raise push; the
//   transfer happens on a clock edge with push high and full low. Mark the last
//   sample of a row with row_end_i. A two-entry queue sits behind the input.
//   Result channel is a queue too: while empty is low, value_o/last_o hold the
//   oldest result; raising pop transfers it. last_o flags the final result of
//   a row. Per row of W samples and T taps, W+T results come out, the first
//   of them always zero.
//   Configuration: write taps and tap_count through cfg_valid_i/cfg_index_i/
//   cfg_data_i only while the block is idle; cfg_ready_o is always high.
// Engine:
//   One shared multiplier walks the taps, so each result takes T products,
//   an accumulate drain and an output write. The first sample of a row also
//   writes a leading zero result first, and a row end adds T-1 flush
//   results.
// Reset clears the queues, the history line and the tap registers, and sets
// tap_count to 4. When the receiver stalls, the output queue fills, the engine
// holds its finished result, and the input queue then backs up into full.
module fir_line_full_correlation #(
  parameter int MAX_TAPS  = flc_pkg::MaxTapsDef,
  parameter int COEF_BITS = flc_pkg::CoefBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input queue
  input  logic                          push,
  output logic                          full,
  input  logic [flc_pkg::SampleW-1:0]   sample_i,
  input  logic                          row_end_i,
  // result queue
  output logic                          empty,
  input  logic                          pop,
  output logic [flc_pkg::SampleW-1:0]   value_o,
  output logic                          last_o,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [flc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [flc_pkg::RegW-1:0]      cfg_data_i
);

  logic [flc_pkg::TapRegs-1:0][flc_pkg::RegW-1:0]     taps_q;
  logic [flc_pkg::CntW-1:0]                           tap_count_q;
  logic [flc_pkg::TapLanes-1:0][flc_pkg::LaneW-1:0]   tap_lanes;
  logic                                               cfg_wr;

  flc_pkg::item_t   item;
  logic             item_valid;
  logic             q_pop;
  flc_pkg::result_t res_in, res_out;
  logic             res_push;
  logic             res_full;

  // Config writes are always taken; tap lanes line up with register order.
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign tap_lanes   = taps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q      <= '0;
      tap_count_q <= flc_pkg::CntW'(flc_pkg::TapCountRst);
    end else if (cfg_wr) begin
      if (cfg_index_i == flc_pkg::CFG_TAP_COUNT) begin
        tap_count_q <= cfg_data_i[flc_pkg::CntW-1:0];
      end else if (cfg_index_i >= flc_pkg::CFG_TAPS_0_3 &&
                   cfg_index_i <= flc_pkg::CFG_TAPS_24_27) begin
        taps_q[cfg_index_i] <= cfg_data_i;
      end
    end
  end

  // Front: tag row starts and queue the samples.
  flc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .sample_i     (sample_i),
    .row_end_i    (row_end_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .pop_i        (q_pop)
  );

  // Back: multiply-accumulate engine, history line and row flush.
  flc_back #(
    .MAX_TAPS  (MAX_TAPS),
    .COEF_BITS (COEF_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .taps_i       (tap_lanes),
    .tap_count_i  (tap_count_q),
    .item_i       (item),
    .item_valid_i (item_valid),
    .q_pop_o      (q_pop),
    .res_o        (res_in),
    .res_push_o   (res_push),
    .res_full_i   (res_full)
  );

  // Output queue decouples the engine from a stalling receiver.
  flc_fifo #(
    .WIDTH ($bits(flc_pkg::result_t)),
    .DEPTH (flc_pkg::OutDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .rd_i    (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign value_o = res_out.value;
  assign last_o  = res_out.last;

endmodule
